@@ design/ctr_pkg.sv @@
// Shared types, codes and the chord template table of the chord template recognizer.
package ctr_pkg;

  // Default configuration of the block
  localparam int NOTE_RANGE_DEF     = 128;
  localparam int TEMPLATE_TOTAL_DEF = 55;
  localparam int COUNT_CAP_DEF      = 16;

  // Entries of the summary queue between the note scanner and the matcher
  localparam int QUEUE_DEPTH = 2;

  localparam logic [11:0] PC_MASK = 12'h0FFF;
  localparam int          PC_NUM  = 12;

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_ALL_OFF  = 2'd2,
    OP_UNUSED   = 2'd3
  } ctr_op_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_SINGLE  = 2'd1,
    KIND_CHORD   = 2'd2,
    KIND_NOMATCH = 2'd3
  } ctr_kind_t;

  // Summary of the held notes after one item
  typedef struct packed {
    logic        any;
    logic [4:0]  count;
    logic [11:0] pcs;
    logic [6:0]  lowest;
    logic [3:0]  bass;
  } ctr_sum_t;

  // Handshake from the scanner towards the queue
  typedef struct packed {
    logic     push;
    ctr_sum_t data;
  } ctr_push_t;

  // Pitch-class templates rooted at C, in table order; empty beyond the list
  function automatic logic [11:0] tmpl_mask(input logic [5:0] idx);
    logic [11:0] m;
    case (idx)
      6'd0:  m = 12'b0110_1010_0101 | 12'b0100_1001_0001;
      6'd1:  m = 12'b1010_1010_0101 | 12'b1000_1001_0001;
      6'd2:  m = 12'b0110_1010_1101 | 12'b0100_1000_1001;
      6'd3:  m = 12'b0100_1011_0101;
      6'd4:  m = 12'b0100_1010_1101;
      6'd5:  m = 12'b1000_1011_0101;
      6'd6:  m = 12'b0110_1001_0101;
      6'd7:  m = 12'b0110_1000_1101;
      6'd8:  m = 12'b0010_1001_0101;
      6'd9:  m = 12'b0010_1000_1101;
      6'd10: m = 12'b0100_1001_0101;
      6'd11: m = 12'b1000_1001_0101;
      6'd12: m = 12'b0100_1000_1101;
      6'd13: m = 12'b0100_1001_0011;
      6'd14: m = 12'b0100_1001_1001;
      6'd15: m = 12'b0100_1101_0001;
      6'd16: m = 12'b0101_1001_0001;
      6'd17: m = 12'b1000_1101_0001;
      6'd18: m = 12'b0100_1000_1011;
      6'd19: m = 12'b1000_1000_1101;
      6'd20: m = 12'b0100_0100_1101;
      6'd21: m = 12'b0100_0100_1011;
      6'd22: m = 12'b0110_1000_1001;
      6'd23: m = 12'b0100_1010_0101;
      6'd24: m = 12'b0100_1011_0001;
      6'd25: m = 12'b0110_1001_0001;
      6'd26: m = 12'b1000_1001_0001;
      6'd27: m = 12'b0100_1001_0001;
      6'd28: m = 12'b0100_1000_1001;
      6'd29: m = 12'b1000_1000_1001;
      6'd30: m = 12'b0010_0100_1001;
      6'd31: m = 12'b0100_0100_1001;
      6'd32: m = 12'b0010_1001_0001;
      6'd33: m = 12'b0010_1000_1001;
      6'd34: m = 12'b0100_1010_0001;
      6'd35: m = 12'b0100_1000_0101;
      6'd36: m = 12'b0000_1001_0101;
      6'd37: m = 12'b0000_1000_1101;
      6'd38: m = 12'b0010_1010_0001;
      6'd39: m = 12'b1000_0100_1001;
      6'd40: m = 12'b0100_0101_0001;
      6'd41: m = 12'b0101_0001_0001;
      6'd42: m = 12'b1000_0101_0001;
      6'd43: m = 12'b1001_0001_0001;
      6'd44: m = 12'b0000_1001_0001;
      6'd45: m = 12'b0000_1000_1001;
      6'd46: m = 12'b0000_0100_1001;
      6'd47: m = 12'b0001_0001_0001;
      6'd48: m = 12'b0000_1000_0101;
      6'd49: m = 12'b0000_1010_0001;
      6'd50: m = 12'b0100_0001_0001;
      6'd51: m = 12'b0100_0000_1001;
      6'd52: m = 12'b0000_1000_0001;
      6'd53: m = 12'b0000_0000_1001;
      6'd54: m = 12'b0000_0001_0001;
      default: m = 12'b0;
    endcase
    return m;
  endfunction

  // Number of pitch classes set in a 12-bit mask
  function automatic logic [3:0] pc_count(input logic [11:0] m);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < PC_NUM; i++) begin
      c = c + 4'(m[i]);
    end
    return c;
  endfunction

  // Rotate a pitch-class mask upward by s classes (s below 12)
  function automatic logic [11:0] pc_rotate(input logic [11:0] m, input logic [3:0] s);
    logic [23:0] w;
    w = {m, m} << s;
    return w[23:12];
  endfunction

endpackage

@@ design/chord_template_recognizer.sv @@
// Top level of the chord template recognizer: scanner, summary queue and matcher.
// Usage:
//   Input channel (in_valid/in_ready): one note event per item: in_opcode
//   note on, note off or all notes off, with in_note and in_velocity.
//   Result channel (out_valid/out_ready): exactly one result item per input
//   item, in order: kind, held count, pitch-class set, lowest note, bass,
//   and for a matched chord its root, template index and slash flag.
//   Throughput: the scanner walks the held-note map one note per cycle; an
//   item occupies the front through accept, scan and push, and in_ready
//   is high only while the scanner is idle.
//   Matching: after the scan the matcher tries one template per cycle,
//   the bass pass then the slash pass, up to the first match; a queue
//   of summaries lets the scanner take the next item while the matcher
//   is busy.
//   Reset (rst_n low, synchronous) releases all notes and empties the queue.
//   A stalled receiver holds the result; the matcher finishes its next item
//   and waits, the queue fills, and a scanner that cannot push keeps in_ready low.
module chord_template_recognizer #(
  parameter int NOTE_RANGE     = ctr_pkg::NOTE_RANGE_DEF,
  parameter int TEMPLATE_TOTAL = ctr_pkg::TEMPLATE_TOTAL_DEF,
  parameter int COUNT_CAP      = ctr_pkg::COUNT_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_note,
  input  logic [6:0]  in_velocity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [4:0]  out_held_count,
  output logic [11:0] out_pitch_set,
  output logic [6:0]  out_lowest_note,
  output logic [3:0]  out_bass_class,
  output logic [3:0]  out_root_class,
  output logic [5:0]  out_template_index,
  output logic        out_is_slash
);
  import ctr_pkg::*;

  ctr_push_t q_wr;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  ctr_sum_t  q_data;

  ctr_front #(
    .NOTE_RANGE (NOTE_RANGE),
    .COUNT_CAP  (COUNT_CAP)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_note     (in_note),
    .in_velocity (in_velocity),
    .q_wr        (q_wr),
    .q_full      (q_full)
  );

  ctr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  ctr_back #(
    .TEMPLATE_TOTAL (TEMPLATE_TOTAL)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_data             (q_data),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_held_count     (out_held_count),
    .out_pitch_set      (out_pitch_set),
    .out_lowest_note    (out_lowest_note),
    .out_bass_class     (out_bass_class),
    .out_root_class     (out_root_class),
    .out_template_index (out_template_index),
    .out_is_slash       (out_is_slash)
  );

  // The scanner never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_wr.push && q_full))
    else $error("summary pushed into full queue");

  // A matched chord names a template inside the table
  a_tix_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_CHORD) |->
      ({1'b0, out_template_index} < 7'(TEMPLATE_TOTAL)))
    else $error("template index beyond table");

  // No notes held gives an all-zero result
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_NONE) |->
      (out_held_count == 5'd0 && out_pitch_set == 12'd0 && out_lowest_note == 7'd0))
    else $error("empty map with non-zero summary");

  // A single note has exactly one pitch class (a cap of one hides extra notes)
  a_single_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_SINGLE && COUNT_CAP > 1) |->
      ($countones(out_pitch_set) == 1))
    else $error("single note with wrong pitch set");

  // A slash chord never sits on the bass
  a_slash_root: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_slash) |-> (out_root_class != out_bass_class))
    else $error("slash chord rooted on bass");

endmodule

@@ design/ctr_front.sv @@
// Front part: accepts note events, keeps the held-note map and scans it into a summary.
module ctr_front #(
  parameter int NOTE_RANGE = ctr_pkg::NOTE_RANGE_DEF,
  parameter int COUNT_CAP  = ctr_pkg::COUNT_CAP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [7:0]        in_note,
  input  logic [6:0]        in_velocity,
  output ctr_pkg::ctr_push_t q_wr,
  input  logic              q_full
);
  import ctr_pkg::*;

  localparam int NW = $clog2(NOTE_RANGE);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SCAN = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t          state_r, state_nxt;
  logic [NOTE_RANGE-1:0] held_r, held_nxt;
  logic [NW-1:0]         idx_r, idx_nxt;
  logic [3:0]            pc_r, pc_nxt;
  ctr_sum_t              sum_r, sum_nxt;
  logic                  in_range;

  assign in_range = {1'b0, in_note} < 9'(NOTE_RANGE);

  // Map update on accept, then one note per cycle through the scan
  always_comb begin
    state_nxt   = state_r;
    held_nxt    = held_r;
    idx_nxt     = idx_r;
    pc_nxt      = pc_r;
    sum_nxt     = sum_r;
    in_ready    = 1'b0;
    q_wr.push   = 1'b0;
    q_wr.data   = sum_r;
    case (state_r)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if ((in_opcode == OP_NOTE_ON || in_opcode == OP_NOTE_OFF) && in_range) begin
            held_nxt[in_note[NW-1:0]] = (in_opcode == OP_NOTE_ON) && (in_velocity != 7'd0);
          end else if (in_opcode == OP_ALL_OFF) begin
            held_nxt = '0;
          end
          idx_nxt   = '0;
          pc_nxt    = 4'd0;
          sum_nxt   = '0;
          state_nxt = F_SCAN;
        end
      end
      F_SCAN: begin
        if (held_r[idx_r]) begin
          sum_nxt.pcs = sum_r.pcs | (12'd1 << pc_r);
          if (!sum_r.any) begin
            sum_nxt.any    = 1'b1;
            sum_nxt.lowest = 7'(idx_r);
            sum_nxt.bass   = pc_r;
          end
          if (sum_r.count < 5'(COUNT_CAP)) begin
            sum_nxt.count = sum_r.count + 5'd1;
          end
        end
        pc_nxt  = (pc_r == 4'(PC_NUM - 1)) ? 4'd0 : pc_r + 4'd1;
        idx_nxt = idx_r + NW'(1);
        if (idx_r == NW'(NOTE_RANGE - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        q_wr.push = !q_full;
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      held_r  <= '0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
    end
  end

  // Scan payload
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pc_r  <= pc_nxt;
    sum_r <= sum_nxt;
  end

endmodule

@@ design/ctr_queue.sv @@
// Short queue of note summaries between the scanner and the template matcher.
module ctr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  ctr_pkg::ctr_push_t wr,
  output logic               full,
  input  logic               pop,
  output ctr_pkg::ctr_sum_t  rd_data,
  output logic               empty
);
  import ctr_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  ctr_sum_t        mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wptr_r, rptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full    = cnt_r == CW'(QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = wr.push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr.data;
    end
  end

endmodule

@@ design/ctr_back.sv @@
// Back part: matches a note summary against the chord templates and holds the result.
module ctr_back #(
  parameter int TEMPLATE_TOTAL = ctr_pkg::TEMPLATE_TOTAL_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  ctr_pkg::ctr_sum_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [4:0]        out_held_count,
  output logic [11:0]       out_pitch_set,
  output logic [6:0]        out_lowest_note,
  output logic [3:0]        out_bass_class,
  output logic [3:0]        out_root_class,
  output logic [5:0]        out_template_index,
  output logic              out_is_slash
);
  import ctr_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_PASS1 = 4'b0010,
    B_PASS2 = 4'b0100,
    B_FIN   = 4'b1000
  } back_state_t;

  back_state_t  state_r, state_nxt;
  ctr_sum_t     sum_r, sum_nxt;
  logic [3:0]   active_r, active_nxt;
  logic [5:0]   tix_r, tix_nxt;
  logic [3:0]   root_r, root_nxt;
  ctr_kind_t    kind_r, kind_nxt;
  logic         slash_r, slash_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         load_out;

  logic [11:0]  cur_mask;
  logic         size_ok;
  logic         last_tmpl;
  logic [11:0]  root_hit;
  logic         any_hit;
  logic [3:0]   first_root;
  logic [3:0]   head_active;

  assign cur_mask    = tmpl_mask(tix_r);
  assign size_ok     = pc_count(cur_mask) == active_r;
  assign last_tmpl   = tix_r == 6'(TEMPLATE_TOTAL - 1);
  assign head_active = pc_count(q_data.pcs);

  // All twelve roots of the current template, bass excluded
  always_comb begin
    root_hit   = '0;
    any_hit    = 1'b0;
    first_root = 4'd0;
    for (int r = 0; r < PC_NUM; r++) begin
      root_hit[r] = size_ok && (pc_rotate(cur_mask, 4'(r)) == sum_r.pcs)
                    && (4'(r) != sum_r.bass);
    end
    for (int r = PC_NUM - 1; r >= 0; r--) begin
      if (root_hit[r]) begin
        any_hit    = 1'b1;
        first_root = 4'(r);
      end
    end
  end

  // Matcher sequencer: bass pass over the table, then the slash pass
  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    active_nxt    = active_r;
    tix_nxt       = tix_r;
    root_nxt      = root_r;
    kind_nxt      = kind_r;
    slash_nxt     = slash_r;
    q_pop         = 1'b0;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          sum_nxt    = q_data;
          active_nxt = head_active;
          tix_nxt    = 6'd0;
          root_nxt   = 4'd0;
          slash_nxt  = 1'b0;
          if (!q_data.any) begin
            kind_nxt  = KIND_NONE;
            state_nxt = B_FIN;
          end else if (q_data.count == 5'd1) begin
            kind_nxt  = KIND_SINGLE;
            state_nxt = B_FIN;
          end else if (head_active < 4'd2) begin
            kind_nxt  = KIND_NOMATCH;
            state_nxt = B_FIN;
          end else begin
            kind_nxt  = KIND_NOMATCH;
            state_nxt = B_PASS1;
          end
        end
      end
      B_PASS1: begin
        if (size_ok && pc_rotate(cur_mask, sum_r.bass) == sum_r.pcs) begin
          kind_nxt  = KIND_CHORD;
          root_nxt  = sum_r.bass;
          state_nxt = B_FIN;
        end else if (last_tmpl) begin
          tix_nxt   = 6'd0;
          state_nxt = B_PASS2;
        end else begin
          tix_nxt = tix_r + 6'd1;
        end
      end
      B_PASS2: begin
        if (any_hit) begin
          kind_nxt  = KIND_CHORD;
          root_nxt  = first_root;
          slash_nxt = 1'b1;
          state_nxt = B_FIN;
        end else if (last_tmpl) begin
          kind_nxt  = KIND_NOMATCH;
          state_nxt = B_FIN;
        end else begin
          tix_nxt = tix_r + 6'd1;
        end
      end
      B_FIN: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r    <= sum_nxt;
    active_r <= active_nxt;
    tix_r    <= tix_nxt;
    root_r   <= root_nxt;
    kind_r   <= kind_nxt;
    slash_r  <= slash_nxt;
  end

  // Output register; match fields read zero unless a chord matched
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind           <= kind_r;
      out_held_count     <= sum_r.count;
      out_pitch_set      <= sum_r.pcs;
      out_lowest_note    <= sum_r.lowest;
      out_bass_class     <= sum_r.bass;
      out_root_class     <= (kind_r == KIND_CHORD) ? root_r : 4'd0;
      out_template_index <= (kind_r == KIND_CHORD) ? tix_r : 6'd0;
      out_is_slash       <= (kind_r == KIND_CHORD) && slash_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
